[rtl/ltw_pkg.sv]
// ----------------------------------------------------------------------------
// ltw_pkg: shared definitions for the load cell readout and weigher
// Field widths, register map, codes of the control program and the
// control ROM itself.
// ----------------------------------------------------------------------------
package ltw_pkg;

  // Field widths of the input and result words.
  localparam int FuncW   = 2;
  localparam int WeightW = 16;
  localparam int RawOutW = 24;
  localparam int DivW    = 16;

  // Default converter word length.
  localparam int SAMPLE_BITS_DEF = 24;

  // Command codes carried by func.
  localparam logic [FuncW-1:0] FUNC_WEIGH = 2'd1;
  localparam logic [FuncW-1:0] FUNC_TARE  = 2'd2;

  // Configuration port.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam int RegIdxW  = CfgAddrW - 2;
  localparam logic [RegIdxW-1:0] REG_SCALE_DIV = 1'd0;
  localparam logic [DivW-1:0]    SCALE_DIV_RST = 16'd437;

  // Program counter values of the control program.
  localparam int StepW = 3;
  localparam logic [StepW-1:0] STEP_IDLE = 3'd0;
  localparam logic [StepW-1:0] STEP_WAIT = 3'd1;
  localparam logic [StepW-1:0] STEP_HIGH = 3'd2;
  localparam logic [StepW-1:0] STEP_LOW  = 3'd3;
  localparam logic [StepW-1:0] STEP_GAIN = 3'd4;
  localparam logic [StepW-1:0] STEP_DIV  = 3'd5;
  localparam logic [StepW-1:0] STEP_FIN  = 3'd6;

  // Jump conditions tested by a control word.
  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_CMD      = 3'd1,
    C_DOUT_LOW = 3'd2,
    C_CNT_LAST = 3'd3,
    C_DIVIDE   = 3'd4
  } cond_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_SHIFT = 3'd2,
    OP_FINAL = 3'd3,
    OP_DIV   = 3'd4,
    OP_WRITE = 3'd5
  } op_e;

  // One branch of a control word: where to go and what to do on the way.
  typedef struct packed {
    logic [StepW-1:0] step;
    op_e              op;
    logic             sck;
    logic             emit;
  } br_t;

  // One control word.
  typedef struct packed {
    logic  take;
    cond_e cond;
    br_t   jmp;
    br_t   nxt;
  } uop_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic cmd;
    logic dout_low;
    logic cnt_last;
    logic divide;
  } stat_t;

  // Control from the sequencer.
  typedef struct packed {
    logic in_ready;
    logic fire;
    op_e  op;
    logic sck;
    logic emit;
    logic busy;
  } ctrl_t;

  // Result word held in the output register.
  typedef struct packed {
    logic               sck;
    logic               busy_res;
    logic [WeightW-1:0] weight;
    logic               weight_valid;
    logic               tare_done;
    logic [RawOutW-1:0] raw_reading;
  } out_word_t;

  function automatic br_t br(input logic [StepW-1:0] step, input op_e op,
                             input logic sck, input logic emit);
    br_t b;
    b.step = step;
    b.op   = op;
    b.sck  = sck;
    b.emit = emit;
    return b;
  endfunction

  // Control ROM. Each tick but the gain tick of a divide emits one result word;
  // the divide loop takes no tick and the finish step emits the weigh result.
  function automatic uop_t ucode(input logic [StepW-1:0] step);
    uop_t u;
    case (step)
      STEP_IDLE: begin
        u = '{take: 1'b1, cond: C_CMD,
              jmp: br(STEP_WAIT, OP_START, 1'b0, 1'b1),
              nxt: br(STEP_IDLE, OP_NONE, 1'b0, 1'b1)};
      end
      STEP_WAIT: begin
        u = '{take: 1'b1, cond: C_DOUT_LOW,
              jmp: br(STEP_HIGH, OP_NONE, 1'b1, 1'b1),
              nxt: br(STEP_WAIT, OP_NONE, 1'b0, 1'b1)};
      end
      STEP_HIGH: begin
        u = '{take: 1'b1, cond: C_ALWAYS,
              jmp: br(STEP_LOW, OP_NONE, 1'b0, 1'b1),
              nxt: br(STEP_LOW, OP_NONE, 1'b0, 1'b1)};
      end
      STEP_LOW: begin
        u = '{take: 1'b1, cond: C_CNT_LAST,
              jmp: br(STEP_GAIN, OP_SHIFT, 1'b1, 1'b1),
              nxt: br(STEP_HIGH, OP_SHIFT, 1'b1, 1'b1)};
      end
      STEP_GAIN: begin
        u = '{take: 1'b1, cond: C_DIVIDE,
              jmp: br(STEP_DIV, OP_FINAL, 1'b0, 1'b0),
              nxt: br(STEP_IDLE, OP_FINAL, 1'b0, 1'b1)};
      end
      STEP_DIV: begin
        u = '{take: 1'b0, cond: C_CNT_LAST,
              jmp: br(STEP_FIN, OP_DIV, 1'b0, 1'b0),
              nxt: br(STEP_DIV, OP_DIV, 1'b0, 1'b0)};
      end
      STEP_FIN: begin
        u = '{take: 1'b0, cond: C_ALWAYS,
              jmp: br(STEP_IDLE, OP_WRITE, 1'b0, 1'b1),
              nxt: br(STEP_IDLE, OP_WRITE, 1'b0, 1'b1)};
      end
      default: begin
        u = '{take: 1'b0, cond: C_ALWAYS,
              jmp: br(STEP_IDLE, OP_NONE, 1'b0, 1'b0),
              nxt: br(STEP_IDLE, OP_NONE, 1'b0, 1'b0)};
      end
    endcase
    return u;
  endfunction

endpackage

[rtl/ltw_in_if.sv]
// ----------------------------------------------------------------------------
// ltw_in_if: tick channel into the weigher
// Valid/ready channel carrying the command and the sampled data line.
// ----------------------------------------------------------------------------
interface ltw_in_if;
  logic                      valid;
  logic                      ready;
  logic [ltw_pkg::FuncW-1:0] func;
  logic                      dout;

  modport source (output valid, output func, output dout, input ready);
  modport sink (input valid, input func, input dout, output ready);
endinterface

[rtl/ltw_out_if.sv]
// ----------------------------------------------------------------------------
// ltw_out_if: result channel out of the weigher
// Valid/ready channel carrying the result words, one per emitting step.
// ----------------------------------------------------------------------------
interface ltw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sck;
  logic                        busy_res;
  logic [ltw_pkg::WeightW-1:0] weight;
  logic                        weight_valid;
  logic                        tare_done;
  logic [ltw_pkg::RawOutW-1:0] raw_reading;

  modport source (output valid, output sck, output busy_res, output weight,
                  output weight_valid, output tare_done, output raw_reading,
                  input ready);
  modport sink (input valid, input sck, input busy_res, input weight,
                input weight_valid, input tare_done, input raw_reading,
                output ready);
endinterface

[rtl/load_cell_adc_tare_weigher_unit.sv]
// ----------------------------------------------------------------------------
// load_cell_adc_tare_weigher_unit: load cell converter readout with tare
// Bit-banged serial readout of a 24-bit bridge converter, tare capture and
// scaling of the net reading to a weight.
// ----------------------------------------------------------------------------
// Each input word is one half-period tick of the serial link; each tick but the
// gain tick of a divide yields one result word, delivered through an output
// register in the cycle after the tick is accepted. After the closing tick of a
// weigh read whose net reading is positive, the net is divided by scale_divisor
// in a restoring divider that forms one quotient bit per cycle while the output
// register can take a word, then a write-back step. A full read spans
// 2*SAMPLE_BITS + 2 ticks from the tick that sees the data line low up to and
// including the gain tick, plus the divide for such a weigh. scale_divisor sits
// at byte address 0 and may be written only while the block is idle; a divisor
// of zero gives a weight of 0xFFFF when the net reading is positive.
// ----------------------------------------------------------------------------
module load_cell_adc_tare_weigher_unit #(
  parameter int SAMPLE_BITS = ltw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ltw_in_if.sink                       in_i,
  ltw_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ltw_pkg::CfgAddrW-1:0] paddr,
  input  logic [ltw_pkg::CfgDataW-1:0] pwdata,
  output logic [ltw_pkg::CfgDataW-1:0] prdata,
  output logic                         pready
);

  logic [ltw_pkg::DivW-1:0]    scale_div_q, scale_div_d;
  logic                        cfg_wr;
  logic                        cfg_hit;
  logic                        out_valid_q, out_valid_d;
  ltw_pkg::out_word_t          out_q, out_d;
  logic                        slot_free;
  ltw_pkg::stat_t              stat;
  ltw_pkg::ctrl_t              ctrl;
  logic [ltw_pkg::WeightW-1:0] weight;
  logic [ltw_pkg::RawOutW-1:0] raw;
  logic                        weight_valid;
  logic                        tare_done;

  // Configuration register.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ltw_pkg::CfgAddrW-1:2] == ltw_pkg::REG_SCALE_DIV);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign scale_div_d = cfg_wr ? pwdata[ltw_pkg::DivW-1:0] : scale_div_q;
  assign prdata  = cfg_hit ? ltw_pkg::CfgDataW'(scale_div_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_div_q <= ltw_pkg::SCALE_DIV_RST;
    end else begin
      scale_div_q <= scale_div_d;
    end
  end

  // Sequencer and datapath.
  assign slot_free = !out_valid_q || out_o.ready;

  ltw_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .slot_free_i (slot_free),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ltw_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .func_i         (in_i.func),
    .dout_i         (in_i.dout),
    .div_i          (scale_div_q),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .weight_o       (weight),
    .raw_o          (raw),
    .weight_valid_o (weight_valid),
    .tare_done_o    (tare_done)
  );

  assign in_i.ready = ctrl.in_ready;

  // Output register: holds one result word until it is taken.
  assign out_d.sck          = ctrl.sck;
  assign out_d.busy_res     = ctrl.busy;
  assign out_d.weight       = weight;
  assign out_d.weight_valid = weight_valid;
  assign out_d.tare_done    = tare_done;
  assign out_d.raw_reading  = raw;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.fire && ctrl.emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.fire && ctrl.emit) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sck          = out_q.sck;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.weight       = out_q.weight;
  assign out_o.weight_valid = out_q.weight_valid;
  assign out_o.tare_done    = out_q.tare_done;
  assign out_o.raw_reading  = out_q.raw_reading;

  // A read ends with exactly one kind of result.
  a_one_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.weight_valid && out_q.tare_done))
    else $error("weight and tare reported in the same word");

  // A finished read always leaves the block idle with the clock low.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.weight_valid || out_q.tare_done) |->
      !out_q.busy_res && !out_q.sck)
    else $error("result reported while still busy");

  // No tick is taken while the divider is running or writing back.
  a_no_tick_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fire && (ctrl.op == ltw_pkg::OP_DIV) |-> !in_i.ready)
    else $error("tick accepted during divide");

  // A weigh result with a weight only follows divide steps or a net reading that is not positive.
  a_write_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.fire && (ctrl.op == ltw_pkg::OP_WRITE) |=> out_valid_q && out_q.weight_valid)
    else $error("divide result not delivered");

endmodule

[rtl/ltw_seq.sv]
// ----------------------------------------------------------------------------
// ltw_seq: control sequencer
// Program counter, control ROM lookup and jump condition select.
// ----------------------------------------------------------------------------
module ltw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            slot_free_i,
  input  ltw_pkg::stat_t  stat_i,
  output ltw_pkg::ctrl_t  ctrl_o
);

  logic [ltw_pkg::StepW-1:0] pc_q, pc_d;
  ltw_pkg::uop_t             uop;
  ltw_pkg::br_t              sel;
  logic                      cond_true;
  logic                      fire;

  // Fetch the control word for the current step.
  assign uop = ltw_pkg::ucode(pc_q);

  // Evaluate the jump condition.
  always_comb begin
    case (uop.cond)
      ltw_pkg::C_ALWAYS:   cond_true = 1'b1;
      ltw_pkg::C_CMD:      cond_true = stat_i.cmd;
      ltw_pkg::C_DOUT_LOW: cond_true = stat_i.dout_low;
      ltw_pkg::C_CNT_LAST: cond_true = stat_i.cnt_last;
      ltw_pkg::C_DIVIDE:   cond_true = stat_i.divide;
      default:             cond_true = 1'b0;
    endcase
  end

  assign sel = cond_true ? uop.jmp : uop.nxt;

  // A step advances once the output register can take a word and, for a
  // step that consumes a tick, a tick is offered.
  assign fire = slot_free_i && (!uop.take || in_valid_i);

  assign pc_d = fire ? sel.step : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ltw_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.in_ready = uop.take && slot_free_i;
  assign ctrl_o.fire     = fire;
  assign ctrl_o.op       = sel.op;
  assign ctrl_o.sck      = sel.sck;
  assign ctrl_o.emit     = sel.emit;
  assign ctrl_o.busy     = (sel.step != ltw_pkg::STEP_IDLE);

endmodule

[rtl/ltw_dp.sv]
// ----------------------------------------------------------------------------
// ltw_dp: readout and weighing datapath
// Shift register, bit counter, tare and result registers, and a restoring
// divider that produces one quotient bit per divide step.
// ----------------------------------------------------------------------------
module ltw_dp #(
  parameter int SAMPLE_BITS = ltw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ltw_pkg::FuncW-1:0]   func_i,
  input  logic                        dout_i,
  input  logic [ltw_pkg::DivW-1:0]    div_i,
  input  ltw_pkg::ctrl_t              ctrl_i,
  output ltw_pkg::stat_t              stat_o,
  output logic [ltw_pkg::WeightW-1:0] weight_o,
  output logic [ltw_pkg::RawOutW-1:0] raw_o,
  output logic                        weight_valid_o,
  output logic                        tare_done_o
);

  localparam int CntW = $clog2(SAMPLE_BITS);
  localparam int RawW = (SAMPLE_BITS > ltw_pkg::RawOutW) ? SAMPLE_BITS : ltw_pkg::RawOutW;
  localparam int RemW = ltw_pkg::DivW;
  localparam logic [SAMPLE_BITS-1:0] TopBit = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [CntW-1:0]        CntLast = CntW'(SAMPLE_BITS - 1);

  logic                         pend_q, pend_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0]       work_q, work_d;
  logic [SAMPLE_BITS-1:0]       tare_q, tare_d;
  logic [RemW-1:0]              rem_q, rem_d;
  logic [ltw_pkg::WeightW-1:0]  quot_q, quot_d;
  logic [ltw_pkg::WeightW-1:0]  weight_q, weight_d;
  logic [ltw_pkg::RawOutW-1:0]  raw_q, raw_d;

  logic [SAMPLE_BITS-1:0]       raw_word;
  logic [RawW-1:0]              raw_ext;
  logic                         net_pos;
  logic [RemW:0]                rem_sh;
  logic [RemW+1:0]              rem_diff;
  logic                         rem_ge;

  // Offset binary word from the assembled bits.
  assign raw_word = work_q ^ TopBit;
  assign raw_ext  = RawW'(raw_word);
  assign net_pos  = (raw_word > tare_q);

  // One restoring divide step: bring in the next dividend bit, then
  // subtract the divisor where it fits.
  assign rem_sh   = {rem_q, work_q[SAMPLE_BITS-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, div_i};
  assign rem_ge   = !rem_diff[RemW+1];

  // Register updates selected by the current operation.
  always_comb begin
    pend_d   = pend_q;
    cnt_d    = cnt_q;
    work_d   = work_q;
    tare_d   = tare_q;
    rem_d    = rem_q;
    quot_d   = quot_q;
    weight_d = weight_q;
    raw_d    = raw_q;
    if (ctrl_i.fire) begin
      case (ctrl_i.op)
        ltw_pkg::OP_START: begin
          pend_d = (func_i == ltw_pkg::FUNC_TARE);
          cnt_d  = '0;
          work_d = '0;
        end
        ltw_pkg::OP_SHIFT: begin
          work_d = {work_q[SAMPLE_BITS-2:0], dout_i};
          cnt_d  = cnt_q + CntW'(1);
        end
        ltw_pkg::OP_FINAL: begin
          raw_d = raw_ext[ltw_pkg::RawOutW-1:0];
          cnt_d = '0;
          if (pend_q) begin
            tare_d = raw_word;
          end else if (net_pos) begin
            work_d = raw_word - tare_q;
            rem_d  = '0;
            quot_d = '0;
          end else begin
            weight_d = '0;
          end
        end
        ltw_pkg::OP_DIV: begin
          rem_d  = rem_ge ? rem_diff[RemW-1:0] : rem_sh[RemW-1:0];
          quot_d = {quot_q[ltw_pkg::WeightW-2:0], rem_ge};
          work_d = {work_q[SAMPLE_BITS-2:0], 1'b0};
          cnt_d  = cnt_q + CntW'(1);
        end
        ltw_pkg::OP_WRITE: begin
          weight_d = quot_q;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and visible state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      cnt_q    <= '0;
      work_q   <= '0;
      tare_q   <= '0;
      weight_q <= '0;
      raw_q    <= '0;
    end else begin
      pend_q   <= pend_d;
      cnt_q    <= cnt_d;
      work_q   <= work_d;
      tare_q   <= tare_d;
      weight_q <= weight_d;
      raw_q    <= raw_d;
    end
  end

  // Divider working registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign stat_o.cmd      = (func_i == ltw_pkg::FUNC_WEIGH) || (func_i == ltw_pkg::FUNC_TARE);
  assign stat_o.dout_low = !dout_i;
  assign stat_o.cnt_last = (cnt_q == CntLast);
  assign stat_o.divide   = !pend_q && net_pos;

  assign weight_o       = weight_d;
  assign raw_o          = raw_d;
  assign tare_done_o    = (ctrl_i.op == ltw_pkg::OP_FINAL) && pend_q;
  assign weight_valid_o = ((ctrl_i.op == ltw_pkg::OP_FINAL) && !pend_q) ||
                          (ctrl_i.op == ltw_pkg::OP_WRITE);

endmodule
